>>> design/rhp_pkg.sv
`timescale 1ns / 1ps
// Package for the RGB to HSV pixel converter: payload types, fixed-point
// widths and the constants of the conversion. No dependencies.
package rhp_pkg;

  // Fraction bits of every result (2^FRAC_BITS stands for one)
  localparam int FRAC_BITS = 16;
  // Quotient bits: results reach exactly one, so one bit above the fraction
  localparam int QUO_W     = FRAC_BITS + 1;
  // Dividend width: 2*n*2^F + 6d with n < 1530 fits in F+12 bits, kept with margin
  localparam int NUM_W     = FRAC_BITS + 13;
  // Divisor width: the largest divisor is 12*255 = 3060
  localparam int DEN_W     = 12;
  // Channel width
  localparam int CH_W      = 8;
  // Width of the small hue sums (6d, n, 12d)
  localparam int SUM_W     = 12;

  // Brightness is max/255, rounded: max times a reciprocal of 255 scaled by
  // 2^(F+VAL_SHIFT), plus one half, then shifted down. The reciprocal error
  // stays below 1/510, the spacing of the exact results, so no floor moves.
  localparam int VAL_SHIFT = 17;
  localparam int VAL_PW    = FRAC_BITS + VAL_SHIFT + 1;
  localparam logic [VAL_PW-1:0] VAL_RECIP =
    VAL_PW'(((longint'(1) << (FRAC_BITS + VAL_SHIFT)) + 254) / 255);
  localparam logic [VAL_PW-1:0] VAL_HALF  = VAL_PW'(longint'(1) << (VAL_SHIFT - 1));

  // Channel that holds the maximum, ties go red, then green
  typedef enum logic [1:0] {
    MAX_RED   = 2'd0,
    MAX_GREEN = 2'd1,
    MAX_BLUE  = 2'd2
  } max_sel_e;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [FRAC_BITS-1:0] hue;
    logic [FRAC_BITS:0]   saturation;
    logic [FRAC_BITS:0]   brightness;
  } hsv_t;

endpackage

>>> design/rhp_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider for the pixel converter: one quotient bit per
// stage, MSB first, quotient known to fit in QW bits. Depends on nothing.
module rhp_div #(
  parameter int NW = 29,
  parameter int DW = 12,
  parameter int QW = 17
) (
  input  logic          clk_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o
);

  logic [NW-1:0] rem_q [QW-1];
  logic [DW-1:0] den_q [QW-1];
  logic [QW-1:0] quo_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int Shift = QW - 1 - k;
    logic [NW-1:0] rem_in;
    logic [NW-1:0] dsh;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quo_in;
    logic          fit;

    // Take the running remainder from the stage above
    if (k == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    // Try the divisor at this bit weight
    assign dsh = NW'(den_in) << Shift;
    assign fit = (rem_in >= dsh);

    always_ff @(posedge clk_i) begin
      quo_q[k] <= {quo_in[QW-2:0], fit};
    end

    // Advance remainder and divisor, the last stage keeps only the quotient
    if (k < QW - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        rem_q[k] <= fit ? (rem_in - dsh) : rem_in;
        den_q[k] <= den_in;
      end
    end
  end

  assign quo_o = quo_q[QW-1];

endmodule

>>> design/rgb_to_hsv_pixel.sv
`timescale 1ns / 1ps
// RGB to HSV pixel converter, top level: channel stages, two pipelined
// dividers and a brightness delay line. Depends on rhp_pkg and rhp_div.
//
// Usage:
//   Request channel: drive pixel_i and raise start_i; the request is taken at
//   any rising edge where start_i is high and busy_o is low. busy_o stays low,
//   so one pixel enters on every clock.
//   Result channel: done_o is high for one cycle with result_o holding hue,
//   saturation and brightness, fractions scaled by 2^FRAC_BITS.
//   Path: an input register, a max/min stage, a numerator stage,
//   FRAC_BITS+1 divider stages and the output register.
//   Throughput: one pixel per cycle, set by the one-bit-per-stage dividers.
//   Results leave in request order, one per request.
//   Reset clears all valid bits, so no stray strobe follows reset.
//   The receiver cannot stall: each result must be taken in its strobe cycle.
module rgb_to_hsv_pixel (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  rhp_pkg::pixel_t pixel_i,
  output logic           done_o,
  output rhp_pkg::hsv_t  result_o
);
  import rhp_pkg::*;

  localparam int VLD_N = QUO_W + 4;

  logic             take;
  logic [VLD_N-1:0] vld_q;

  pixel_t           pix1_q;
  pixel_t           pix2_q;
  logic [CH_W-1:0]  mx_d, mn_d, mx_q, d_q;
  max_sel_e         sel_d, sel_q;

  logic [SUM_W-1:0] r12, g12, b12, d12, six_d, n_d;
  logic             grey;
  logic [NUM_W-1:0] hnum_d, hnum_q, snum_d, snum_q;
  logic [DEN_W-1:0] hden_d, hden_q, sden_d, sden_q;
  logic [VAL_PW-1:0] vprod;
  logic [QUO_W-1:0] vval_q;
  logic [QUO_W-1:0] vdly_q [QUO_W];

  logic [QUO_W-1:0] hquo, squo, vquo;
  hsv_t             result_q;

  // Pipeline never holds off a request
  assign busy_o = 1'b0;
  assign take   = start_i & ~busy_o;

  // Advance the valid bits alongside the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[VLD_N-2:0], take};
    end
  end

  // Stage 1: hold the incoming pixel
  always_ff @(posedge clk_i) begin
    pix1_q <= pixel_i;
  end

  // Stage 2: find max, min and the channel that wins
  always_comb begin
    mx_d  = pix1_q.red;
    sel_d = MAX_RED;
    if (pix1_q.green > mx_d) begin
      mx_d  = pix1_q.green;
      sel_d = MAX_GREEN;
    end
    if (pix1_q.blue > mx_d) begin
      mx_d  = pix1_q.blue;
      sel_d = MAX_BLUE;
    end
    mn_d = pix1_q.red;
    if (pix1_q.green < mn_d) mn_d = pix1_q.green;
    if (pix1_q.blue < mn_d)  mn_d = pix1_q.blue;
  end

  always_ff @(posedge clk_i) begin
    pix2_q <= pix1_q;
    mx_q   <= mx_d;
    d_q    <= mx_d - mn_d;
    sel_q  <= sel_d;
  end

  // Stage 3: form rounded dividends and divisors
  always_comb begin
    r12   = SUM_W'(pix2_q.red);
    g12   = SUM_W'(pix2_q.green);
    b12   = SUM_W'(pix2_q.blue);
    d12   = SUM_W'(d_q);
    six_d = (d12 << 2) + (d12 << 1);
    grey  = (d_q == '0);
    case (sel_q)
      MAX_RED: begin
        if (g12 >= b12) n_d = g12 - b12;
        else            n_d = six_d - (b12 - g12);
      end
      MAX_GREEN: n_d = (d12 << 1) + b12 - r12;
      MAX_BLUE:  n_d = (d12 << 2) + r12 - g12;
      default:   n_d = '0;
    endcase
    // Grey pixel: zero over one gives zero hue and saturation
    if (grey) begin
      hnum_d = '0;
      hden_d = DEN_W'(1);
      snum_d = '0;
      sden_d = DEN_W'(1);
    end else begin
      hnum_d = (NUM_W'(n_d) << (FRAC_BITS + 1)) + NUM_W'(six_d);
      hden_d = DEN_W'((d12 << 3) + (d12 << 2));
      snum_d = (NUM_W'(d_q) << (FRAC_BITS + 1)) + NUM_W'(mx_q);
      sden_d = DEN_W'({mx_q, 1'b0});
    end
  end

  // Brightness by reciprocal multiplication of the maximum
  assign vprod = VAL_PW'(mx_q) * VAL_RECIP + VAL_HALF;

  always_ff @(posedge clk_i) begin
    hnum_q <= hnum_d;
    hden_q <= hden_d;
    snum_q <= snum_d;
    sden_q <= sden_d;
    vval_q <= vprod[VAL_SHIFT +: QUO_W];
  end

  // Divide hue and saturation in lockstep
  rhp_div #(.NW(NUM_W), .DW(DEN_W), .QW(QUO_W)) u_hue_div (
    .clk_i (clk_i),
    .num_i (hnum_q),
    .den_i (hden_q),
    .quo_o (hquo)
  );

  rhp_div #(.NW(NUM_W), .DW(DEN_W), .QW(QUO_W)) u_sat_div (
    .clk_i (clk_i),
    .num_i (snum_q),
    .den_i (sden_q),
    .quo_o (squo)
  );

  // Delay brightness to line up with the divider outputs
  always_ff @(posedge clk_i) begin
    vdly_q[0] <= vval_q;
    for (int k = 1; k < QUO_W; k++) begin
      vdly_q[k] <= vdly_q[k-1];
    end
  end

  assign vquo = vdly_q[QUO_W-1];

  // Output register: drop the top hue bit so a full turn wraps to zero
  always_ff @(posedge clk_i) begin
    result_q.hue        <= hquo[FRAC_BITS-1:0];
    result_q.saturation <= squo;
    result_q.brightness <= vquo;
  end

  assign done_o   = vld_q[VLD_N-1];
  assign result_o = result_q;

`ifndef SYNTHESIS
  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> ##VLD_N done_o)
    else $error("request did not produce a result at the fixed latency");

  a_no_stray : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(take, VLD_N))
    else $error("result strobe without a matching request");

  a_sat_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.saturation <= ONE))
    else $error("saturation above one");

  a_val_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.brightness <= ONE))
    else $error("brightness above one");
`endif

endmodule

>>> tb/rgb_to_hsv_pixel_checker.sv
`timescale 1ns / 1ps
// Checker for the RGB to HSV pixel converter: watches the request and result
// channels, predicts each result and compares it field by field. Needs rhp_pkg.
module rgb_to_hsv_pixel_checker (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            busy_i,
  input  rhp_pkg::pixel_t pixel_i,
  input  logic            done_i,
  input  rhp_pkg::hsv_t   result_i,
  output int              fail_count_o,
  output int              pending_o
);
  import rhp_pkg::*;

  // Results still owed by the block, oldest first
  hsv_t hsv_expected_q[$];

  // Exact HSV of one pixel, each field rounded to nearest with halves up
  function automatic hsv_t hsv_of_pixel(pixel_t px);
    longint    r, g, b, mx, mn, d, n, one, hue, sat, val;
    max_sel_e  top;
    hsv_t      res;
    one = longint'(1) << FRAC_BITS;
    r = px.red;
    g = px.green;
    b = px.blue;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    // Ties go to red first, then green
    if (r == mx) top = MAX_RED;
    else if (g == mx) top = MAX_GREEN;
    else top = MAX_BLUE;
    val = (2 * mx * one + 255) / 510;
    hue = 0;
    sat = 0;
    // Grey pixels keep hue and saturation at zero
    if (d != 0) begin
      sat = (2 * d * one + mx) / (2 * mx);
      case (top)
        MAX_RED: begin
          n = g - b;
          if (n < 0) n = n + 6 * d;
        end
        MAX_GREEN: n = 2 * d + b - r;
        default:   n = 4 * d + r - g;
      endcase
      hue = (2 * n * one + 6 * d) / (12 * d);
      // A hue of one full turn wraps to zero
      if (hue >= one) hue = hue - one;
    end
    res.hue        = hue[FRAC_BITS-1:0];
    res.saturation = sat[FRAC_BITS:0];
    res.brightness = val[FRAC_BITS:0];
    return res;
  endfunction

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  // Check results against the oldest expectation, then queue new requests
  always @(posedge clk_i) begin
    hsv_t want;
    if (rst_ni) begin
      if (done_i) begin
        if (hsv_expected_q.size() == 0) begin
          $error("result with no request waiting: hue %0d saturation %0d brightness %0d",
                 result_i.hue, result_i.saturation, result_i.brightness);
          fail_count_o++;
        end else begin
          want = hsv_expected_q.pop_front();
          if (result_i.hue !== want.hue) begin
            $error("hue: expected %0d, got %0d", want.hue, result_i.hue);
            fail_count_o++;
          end
          if (result_i.saturation !== want.saturation) begin
            $error("saturation: expected %0d, got %0d", want.saturation,
                   result_i.saturation);
            fail_count_o++;
          end
          if (result_i.brightness !== want.brightness) begin
            $error("brightness: expected %0d, got %0d", want.brightness,
                   result_i.brightness);
            fail_count_o++;
          end
        end
      end
      if (start_i && !busy_i) hsv_expected_q.push_back(hsv_of_pixel(pixel_i));
      pending_o = hsv_expected_q.size();
    end
  end

endmodule

>>> tb/rgb_to_hsv_pixel_tb.sv
`timescale 1ns / 1ps
// Testbench top for the RGB to HSV pixel converter: clock, reset, directed and
// random pixel requests, verdict. Needs rhp_pkg, the block and the checker.
module rgb_to_hsv_pixel_tb;
  import rhp_pkg::*;

  localparam int RANDOM_PIXELS = 600;
  localparam int CYCLE_LIMIT   = 60000;
  localparam int DRAIN_CYCLES  = 40;

  logic   clk_i;
  logic   rst_ni;
  logic   start_i;
  logic   busy_o;
  pixel_t pixel_i;
  logic   done_o;
  hsv_t   result_o;
  int     fail_count;
  int     pending;
  int     cycle_count;
  bit     idle_on;

  rgb_to_hsv_pixel u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .pixel_i (pixel_i),
    .done_o  (done_o),
    .result_o(result_o)
  );

  rgb_to_hsv_pixel_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_i      (busy_o),
    .pixel_i     (pixel_i),
    .done_i      (done_o),
    .result_i    (result_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Count cycles for the run limit
  initial cycle_count = 0;
  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // End a hung run
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  // Issue one request, hold it until taken, then idle for the drawn gap
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    int gap;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    @(negedge clk_i);
    start_i <= 1'b1;
    pixel_i <= '{red: r, green: g, blue: b};
    do @(posedge clk_i); while (busy_o);
    // Drive junk on the idle pixel bus
    repeat (gap) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      pixel_i <= pixel_t'(24'($urandom));
    end
  endtask

  // Drop the request line and hold off until every result is back
  task automatic wait_idle();
    @(negedge clk_i);
    start_i <= 1'b0;
    wait (pending == 0);
  endtask

  // Random pixel, biased toward grey pixels, ties and extreme channels
  task automatic send_random_pixel();
    logic [7:0] hi, lo;
    int kind;
    kind = $urandom_range(0, 9);
    hi = 8'($urandom_range(1, 255));
    lo = 8'($urandom_range(0, hi - 1));
    case (kind)
      0: send_pixel(hi, hi, hi);
      1: send_pixel(hi, hi, lo);
      2: send_pixel(lo, hi, hi);
      3: send_pixel(hi, lo, hi);
      4: send_pixel($urandom_range(0, 1) ? 8'd255 : 8'd0,
                    $urandom_range(0, 1) ? 8'd255 : 8'd0,
                    $urandom_range(0, 1) ? 8'd255 : 8'd0);
      default: send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)));
    endcase
  endtask

  initial begin
    rst_ni  = 1'b0;
    start_i = 1'b0;
    pixel_i = '0;
    idle_on = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Grey pixels, black and white among them
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd1, 8'd1, 8'd1);
    // Primaries
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    // Ties for the maximum
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
    // One channel full, one at one: red maximum with blue above green is just below a full turn
    send_pixel(8'd255, 8'd0, 8'd1);
    send_pixel(8'd255, 8'd1, 8'd0);
    send_pixel(8'd1, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd1);
    send_pixel(8'd1, 8'd0, 8'd255);
    send_pixel(8'd0, 8'd1, 8'd255);
    // Smallest maximum and smallest spread
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd1);
    send_pixel(8'd255, 8'd254, 8'd254);
    send_pixel(8'd255, 8'd255, 8'd254);
    // Assorted hues
    send_pixel(8'd170, 8'd85, 8'd0);
    send_pixel(8'd85, 8'd170, 8'd255);
    send_pixel(8'd37, 8'd200, 8'd113);
    send_pixel(8'd200, 8'd100, 8'd50);
    wait_idle();

    // Random pixels in stretches with and without idle gaps
    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      if (i % 40 == 0) idle_on = $urandom_range(0, 2) != 0;
      if (i == RANDOM_PIXELS / 2) wait_idle();
      send_random_pixel();
    end
    @(negedge clk_i);
    start_i <= 1'b0;

    // Drain, then watch for stray results
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
